FILE: sv/key_value_option_tokenizer_core_assert.svh
// ----------------------------------------------------------------------------
// Key/value option tokenizer assertion macros
// Concurrent check macros, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_OPTION_TOKENIZER_CORE_ASSERT_SVH
`define KEY_VALUE_OPTION_TOKENIZER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define KVOT_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("kvot: implication violated");

`define KVOT_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("kvot: forbidden condition");

`else

`define KVOT_ASSERT_IMPLY(label, clk, rst_n, cond, prop)

`define KVOT_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: sv/kvot_pkg.sv
// ----------------------------------------------------------------------------
// Key/value option tokenizer package
// Shared types and constants for the front classifier and back scanner.
// ----------------------------------------------------------------------------
package kvot_pkg;

	localparam int CHAR_W  = 16;
	localparam int START_W = 12;
	localparam int LEN_W   = 13;
	localparam int TDATA_OUT_W = 56;

	localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
	localparam logic [CHAR_W-1:0] CH_EQUAL = 16'h003D;
	localparam logic [CHAR_W-1:0] CH_QUOTE = 16'h0022;

	localparam logic [START_W-1:0] START_FIELD_MAX  = 12'd4095;
	localparam logic [LEN_W-1:0]   LENGTH_FIELD_MAX = 13'd4096;

	localparam int QD    = 2;
	localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
	localparam int LVL_W = $clog2(QD + 1);

	typedef struct packed {
		logic is_space;
		logic is_equal;
		logic is_quote;
		logic last;
	} token_t;

	typedef struct packed {
		logic             full;
		logic             empty;
		logic [LVL_W-1:0] level;
	} q_status_t;

	typedef struct packed {
		logic               overflow;
		logic               value_present;
		logic [LEN_W-1:0]   value_length;
		logic [START_W-1:0] value_start;
		logic               key_present;
		logic [LEN_W-1:0]   key_length;
		logic [START_W-1:0] key_start;
	} item_t;

endpackage

FILE: sv/kvot_front.sv
// ----------------------------------------------------------------------------
// Key/value option tokenizer front end
// Classifies each character and queues the token for the back scanner.
// ----------------------------------------------------------------------------
module kvot_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [kvot_pkg::CHAR_W-1:0]   char_code,
	input  logic                          last_of_line,
	output logic                          tok_valid,
	output kvot_pkg::token_t              tok,
	input  logic                          tok_pop,
	output kvot_pkg::q_status_t           q_stat
);
	import kvot_pkg::*;

	token_t           entry_q [QD];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	token_t           tok_in;
	logic             push;

	always_comb begin
		tok_in.is_space = (char_code == CH_SPACE);
		tok_in.is_equal = (char_code == CH_EQUAL);
		tok_in.is_quote = (char_code == CH_QUOTE);
		tok_in.last     = last_of_line;
	end

	assign s_tready     = (level_q != LVL_W'(QD));
	assign push         = s_tvalid && s_tready;
	assign tok_valid    = (level_q != '0);
	assign tok          = entry_q[rd_ptr_q];
	assign q_stat.full  = !s_tready;
	assign q_stat.empty = !tok_valid;
	assign q_stat.level = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= tok_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (tok_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, tok_pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

FILE: sv/kvot_back.sv
// ----------------------------------------------------------------------------
// Key/value option tokenizer back end
// Runs the scan state machine on queued tokens and registers finished items.
// ----------------------------------------------------------------------------
module kvot_back #(
	parameter int MAX_LINE = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tok_valid,
	input  kvot_pkg::token_t tok,
	output logic             tok_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output kvot_pkg::item_t  item
);
	import kvot_pkg::*;

	localparam int PW = $clog2(MAX_LINE + 1);
	localparam int EW = (PW > LEN_W) ? PW : LEN_W;
	localparam logic [PW-1:0] LIMIT    = PW'(MAX_LINE);
	localparam logic [PW-1:0] LAST_POS = PW'(MAX_LINE - 1);

	typedef enum logic [1:0] {
		MODE_SKIP,
		MODE_KEY,
		MODE_ASSIGN,
		MODE_VALUE
	} mode_t;

	mode_t         mode_q, mode_n;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] key_start_q, key_start_n;
	logic [PW-1:0] key_len_q, key_len_n;
	logic [PW-1:0] val_start_q, val_start_n;
	logic [PW-1:0] val_len_q, val_len_n;
	logic          eq_q, eq_n;
	logic          quoted_q, quoted_n;
	logic          closed_q, closed_n;
	logic          ovf_q, ovf_n;
	logic          m_tvalid_q;
	item_t         item_q;

	logic [PW-1:0] pc;
	logic          emit;
	logic          kp, vp;
	logic [EW-1:0] ks_e, kl_e, vs_e, vl_e;
	item_t         item_n;

	function automatic logic [PW-1:0] grow(input logic [PW-1:0] len);
		return (len < LIMIT) ? len + 1'b1 : LIMIT;
	endfunction

	assign tok_pop  = tok_valid && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign item     = item_q;

	always_comb begin
		ovf_n       = ovf_q || (pos_q >= LIMIT);
		pc          = (pos_q >= LIMIT) ? LAST_POS : pos_q;
		mode_n      = mode_q;
		key_start_n = key_start_q;
		key_len_n   = key_len_q;
		val_start_n = val_start_q;
		val_len_n   = val_len_q;
		eq_n        = eq_q;
		quoted_n    = quoted_q;
		closed_n    = closed_q;
		emit        = 1'b0;
		unique case (mode_q)
			MODE_KEY: begin
				if (tok.is_space) begin
					eq_n   = 1'b0;
					mode_n = MODE_ASSIGN;
				end else if (tok.is_equal) begin
					eq_n   = 1'b1;
					mode_n = MODE_ASSIGN;
				end else begin
					key_len_n = grow(key_len_q);
				end
			end
			MODE_ASSIGN: begin
				if (tok.is_space) begin
					mode_n = MODE_ASSIGN;
				end else if (tok.is_equal && !eq_q) begin
					eq_n = 1'b1;
				end else begin
					val_start_n = pc;
					val_len_n   = PW'(1);
					quoted_n    = tok.is_quote;
					closed_n    = 1'b0;
					mode_n      = MODE_VALUE;
				end
			end
			MODE_VALUE: begin
				if (tok.is_space && (!quoted_q || closed_q)) begin
					emit   = 1'b1;
					mode_n = MODE_SKIP;
				end else begin
					if (quoted_q && tok.is_quote) begin
						closed_n = 1'b1;
					end
					val_len_n = grow(val_len_q);
				end
			end
			MODE_SKIP: begin
				if (!tok.is_space) begin
					key_start_n = tok.is_equal ? '0 : pc;
					key_len_n   = tok.is_equal ? '0 : PW'(1);
					val_start_n = '0;
					val_len_n   = '0;
					eq_n        = tok.is_equal;
					quoted_n    = 1'b0;
					closed_n    = 1'b0;
					mode_n      = tok.is_equal ? MODE_ASSIGN : MODE_KEY;
				end
			end
			default: mode_n = MODE_SKIP;
		endcase
		if (tok.last && (mode_n != MODE_SKIP)) begin
			emit = 1'b1;
		end

		kp   = (key_len_n != '0);
		vp   = (val_len_n != '0);
		ks_e = EW'(key_start_n);
		kl_e = EW'(key_len_n);
		vs_e = EW'(val_start_n);
		vl_e = EW'(val_len_n);
		item_n.key_start     = !kp ? '0 :
			(ks_e > EW'(START_FIELD_MAX)) ? START_FIELD_MAX : ks_e[START_W-1:0];
		item_n.key_length    = !kp ? '0 :
			(kl_e > EW'(LENGTH_FIELD_MAX)) ? LENGTH_FIELD_MAX : kl_e[LEN_W-1:0];
		item_n.key_present   = kp;
		item_n.value_start   = !vp ? '0 :
			(vs_e > EW'(START_FIELD_MAX)) ? START_FIELD_MAX : vs_e[START_W-1:0];
		item_n.value_length  = !vp ? '0 :
			(vl_e > EW'(LENGTH_FIELD_MAX)) ? LENGTH_FIELD_MAX : vl_e[LEN_W-1:0];
		item_n.value_present = vp;
		item_n.overflow      = ovf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_SKIP;
			pos_q       <= '0;
			key_start_q <= '0;
			key_len_q   <= '0;
			val_start_q <= '0;
			val_len_q   <= '0;
			eq_q        <= 1'b0;
			quoted_q    <= 1'b0;
			closed_q    <= 1'b0;
			ovf_q       <= 1'b0;
			m_tvalid_q  <= 1'b0;
			item_q      <= '0;
		end else if (tok_pop) begin
			m_tvalid_q <= emit;
			if (emit) begin
				item_q <= item_n;
			end
			if (tok.last) begin
				mode_q      <= MODE_SKIP;
				pos_q       <= '0;
				key_start_q <= '0;
				key_len_q   <= '0;
				val_start_q <= '0;
				val_len_q   <= '0;
				eq_q        <= 1'b0;
				quoted_q    <= 1'b0;
				closed_q    <= 1'b0;
				ovf_q       <= 1'b0;
			end else begin
				mode_q      <= mode_n;
				pos_q       <= grow(pos_q);
				key_start_q <= key_start_n;
				key_len_q   <= key_len_n;
				val_start_q <= val_start_n;
				val_len_q   <= val_len_n;
				eq_q        <= eq_n;
				quoted_q    <= quoted_n;
				closed_q    <= closed_n;
				ovf_q       <= ovf_n;
			end
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

endmodule

FILE: sv/key_value_option_tokenizer_core.sv
// ----------------------------------------------------------------------------
// Key/value option tokenizer core
// Splits a stream of 16-bit characters into key/value items with positions.
// ----------------------------------------------------------------------------
// A result is registered in the token queue and then in the item register before m_tvalid.
// Throughput: one character per cycle, unless a pending result is held while m_tready is low.
// A two-entry token queue decouples the classifier from the scanner.
// Reset (arst_n low) empties the queue, drops any pending result and
// starts a fresh line at position 0.
`include "key_value_option_tokenizer_core_assert.svh"

module key_value_option_tokenizer_core #(
	parameter int MAX_LINE = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] char_code
	input  logic        s_tlast,   // last_of_line
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // [11:0] key_start, [24:12] key_length,
	                               // [25] key_present, [37:26] value_start,
	                               // [50:38] value_length, [51] value_present,
	                               // [52] overflow, [55:53] zero
);
	import kvot_pkg::*;

	logic      tok_valid;
	token_t    tok;
	logic      tok_pop;
	q_status_t q_stat;
	item_t     out_item;

	kvot_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.char_code    (s_tdata),
		.last_of_line (s_tlast),
		.tok_valid    (tok_valid),
		.tok          (tok),
		.tok_pop      (tok_pop),
		.q_stat       (q_stat)
	);

	kvot_back #(
		.MAX_LINE (MAX_LINE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_pop   (tok_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.item      (out_item)
	);

	assign m_tdata = {(TDATA_OUT_W - $bits(item_t))'(0), out_item};

	`KVOT_ASSERT_NEVER(a_queue_level, clk, arst_n, q_stat.level > LVL_W'(QD))
	`KVOT_ASSERT_IMPLY(a_pop_nonempty, clk, arst_n, tok_pop, !q_stat.empty)
	`KVOT_ASSERT_IMPLY(a_key_len, clk, arst_n, m_tvalid && out_item.key_present, out_item.key_length != '0)
	`KVOT_ASSERT_IMPLY(a_val_len, clk, arst_n, m_tvalid && out_item.value_present, out_item.value_length != '0)

endmodule

FILE: tb/tb_key_value_option_tokenizer_core.sv
// ----------------------------------------------------------------------------
// Key/value option tokenizer core testbench
// Streams command lines into the tokenizer and scores every emitted item
// against a cycle-free line scanner kept in the scoreboard. Directed lines
// cover the scan modes, empty keys and quoted values.
// Random well-formed lines, noise and cut-off lines follow, with random
// gaps and stalls on both streams, one long output hold-off and drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_key_value_option_tokenizer_core;

	import kvot_pkg::*;

	localparam int LINE_LIMIT   = 4096;
	localparam int RANDOM_ITEMS = 650;
	localparam int LONG_HOLD    = 300;
	localparam int CYCLE_LIMIT  = 2000000;

	typedef enum logic [1:0] {
		SCAN_SKIP,
		SCAN_KEY,
		SCAN_ASSIGN,
		SCAN_VALUE
	} scan_mode_e;

	class tokenizer_scoreboard;
		scan_mode_e  mode;
		int unsigned pos;
		int unsigned key_start;
		int unsigned key_len;
		int unsigned val_start;
		int unsigned val_len;
		bit          eq_seen;
		bit          quoted;
		bit          closed;
		bit          ovf;
		item_t       expected_items[$];
		int          mismatches;

		function new();
			clear_line();
			mismatches = 0;
		endfunction

		function void clear_item();
			key_start = 0;
			key_len   = 0;
			val_start = 0;
			val_len   = 0;
			eq_seen   = 1'b0;
			quoted    = 1'b0;
			closed    = 1'b0;
		endfunction

		function void clear_line();
			clear_item();
			mode = SCAN_SKIP;
			pos  = 0;
			ovf  = 1'b0;
		endfunction

		function int unsigned grow(int unsigned n);
			return (n < LINE_LIMIT) ? n + 1 : LINE_LIMIT;
		endfunction

		function int unsigned clip(int unsigned v, int unsigned hi);
			return (v > hi) ? hi : v;
		endfunction

		function void store_item();
			item_t it;
			bit    kp;
			bit    vp;
			kp = (key_len != 0);
			vp = (val_len != 0);
			it.key_start     = kp ? START_W'(clip(key_start, START_FIELD_MAX)) : '0;
			it.key_length    = kp ? LEN_W'(clip(key_len, LENGTH_FIELD_MAX)) : '0;
			it.key_present   = kp;
			it.value_start   = vp ? START_W'(clip(val_start, START_FIELD_MAX)) : '0;
			it.value_length  = vp ? LEN_W'(clip(val_len, LENGTH_FIELD_MAX)) : '0;
			it.value_present = vp;
			it.overflow      = ovf;
			expected_items.push_back(it);
		endfunction

		function void note_input(logic [15:0] c, bit last);
			int unsigned pc;
			bit          emitted;
			emitted = 1'b0;
			if (pos >= LINE_LIMIT)
				ovf = 1'b1;
			pc = (pos > LINE_LIMIT - 1) ? LINE_LIMIT - 1 : pos;
			case (mode)
				SCAN_KEY: begin
					if (c == CH_SPACE) begin
						eq_seen = 1'b0;
						mode = SCAN_ASSIGN;
					end else if (c == CH_EQUAL) begin
						eq_seen = 1'b1;
						mode = SCAN_ASSIGN;
					end else begin
						key_len = grow(key_len);
					end
				end
				SCAN_ASSIGN: begin
					if (c == CH_SPACE) begin
					end else if (c == CH_EQUAL && !eq_seen) begin
						eq_seen = 1'b1;
					end else begin
						val_start = pc;
						val_len   = 1;
						quoted    = (c == CH_QUOTE);
						closed    = 1'b0;
						mode      = SCAN_VALUE;
					end
				end
				SCAN_VALUE: begin
					if (c == CH_SPACE && (!quoted || closed)) begin
						store_item();
						emitted = 1'b1;
						mode = SCAN_SKIP;
					end else begin
						if (quoted && c == CH_QUOTE)
							closed = 1'b1;
						val_len = grow(val_len);
					end
				end
				default: begin
					if (c != CH_SPACE) begin
						clear_item();
						if (c == CH_EQUAL) begin
							eq_seen = 1'b1;
							mode = SCAN_ASSIGN;
						end else begin
							key_start = pc;
							key_len   = 1;
							mode      = SCAN_KEY;
						end
					end
				end
			endcase
			if (last) begin
				if (!emitted && mode != SCAN_SKIP)
					store_item();
				clear_line();
			end else begin
				pos = grow(pos);
			end
		endfunction

		function void report(string field, int unsigned exp_val, int unsigned act_val);
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH %s: expected %0d, actual %0d", field, exp_val, act_val);
		endfunction

		function void check_result(logic [55:0] data);
			item_t got;
			item_t exp;
			got = item_t'(data[52:0]);
			if (expected_items.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("MISMATCH unexpected transaction, tdata %h", data);
				return;
			end
			exp = expected_items.pop_front();
			if (got.key_start !== exp.key_start)
				report("key_start", exp.key_start, got.key_start);
			if (got.key_length !== exp.key_length)
				report("key_length", exp.key_length, got.key_length);
			if (got.key_present !== exp.key_present)
				report("key_present", exp.key_present, got.key_present);
			if (got.value_start !== exp.value_start)
				report("value_start", exp.value_start, got.value_start);
			if (got.value_length !== exp.value_length)
				report("value_length", exp.value_length, got.value_length);
			if (got.value_present !== exp.value_present)
				report("value_present", exp.value_present, got.value_present);
			if (got.overflow !== exp.overflow)
				report("overflow", exp.overflow, got.overflow);
		endfunction

		function int pending();
			return expected_items.size();
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;

	tokenizer_scoreboard sb = new();

	logic [15:0] line_chars[$];
	int          items_sent  = 0;
	bit          no_idle     = 1'b0;
	int          hold_ticket = 0;
	int          hold_taken  = 0;
	int          stall_left  = 0;
	int          run_left    = 0;
	int          ready_pick;

	key_value_option_tokenizer_core #(
		.MAX_LINE(LINE_LIMIT)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: score accepted transactions, then choose the next ready level
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (hold_ticket != hold_taken) begin
			hold_taken <= hold_ticket;
			stall_left <= LONG_HOLD;
			m_tready   <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (no_idle || run_left > 0) begin
			if (run_left > 0)
				run_left <= run_left - 1;
			m_tready <= arst_n;
		end else begin
			ready_pick = $urandom_range(99);
			if (ready_pick < 70) begin
				run_left <= $urandom_range(20, 1);
				m_tready <= arst_n;
			end else begin
				stall_left <= (ready_pick < 96) ? $urandom_range(2, 0) : $urandom_range(40, 10);
				m_tready   <= 1'b0;
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		if (r < 98)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic [15:0] word_char(bit allow_equal);
		int          r;
		logic [15:0] c;
		r = $urandom_range(11);
		if (r < 6)
			return 16'(16'h0061 + $urandom_range(25));
		if (r < 8)
			return 16'(16'h0030 + $urandom_range(9));
		if (r == 8)
			return CH_QUOTE;
		if (r == 9 && allow_equal)
			return CH_EQUAL;
		c = 16'($urandom_range(65535));
		if (c == CH_SPACE || c == CH_EQUAL)
			c = c ^ 16'h8000;
		return c;
	endfunction

	function automatic logic [15:0] noise_char();
		int r;
		r = $urandom_range(9);
		if (r < 3)
			return CH_SPACE;
		if (r == 3)
			return CH_EQUAL;
		if (r == 4)
			return CH_QUOTE;
		return 16'($urandom_range(65535));
	endfunction

	task automatic send_char(logic [15:0] c, bit last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_input(c, last);
		items_sent++;
	endtask

	task automatic send_text(string s, bit mark_last);
		for (int i = 0; i < s.len(); i++)
			send_char({8'h00, s[i]}, mark_last && (i == s.len() - 1));
	endtask

	// hold the input idle until every expected transaction has been scored
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic build_line();
		int  n_opts;
		int  r;
		int  cut;
		bit  empty_key;
		line_chars.delete();
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(12, 1))
				line_chars.push_back(noise_char());
			return;
		end
		n_opts = $urandom_range(3, 1);
		for (int i = 0; i < n_opts; i++) begin
			if (i > 0)
				line_chars.push_back(CH_SPACE);
			repeat ($urandom_range(2, 0))
				line_chars.push_back(CH_SPACE);
			empty_key = ($urandom_range(9) == 0);
			if (!empty_key)
				repeat ($urandom_range(5, 1))
					line_chars.push_back(word_char(1'b0));
			r = empty_key ? (($urandom_range(1) == 0) ? 1 : 3) : $urandom_range(4);
			case (r)
				0: line_chars.push_back(CH_SPACE);
				1: line_chars.push_back(CH_EQUAL);
				2: begin
					line_chars.push_back(CH_SPACE);
					line_chars.push_back(CH_EQUAL);
					line_chars.push_back(CH_SPACE);
				end
				3: begin
					line_chars.push_back(CH_EQUAL);
					line_chars.push_back(CH_EQUAL);
				end
				default: begin
					line_chars.push_back(CH_SPACE);
					line_chars.push_back(CH_EQUAL);
				end
			endcase
			r = $urandom_range(9);
			if (r < 4) begin
				repeat ($urandom_range(5, 1))
					line_chars.push_back(word_char(1'b1));
			end else if (r < 8) begin
				line_chars.push_back(CH_QUOTE);
				repeat ($urandom_range(4, 0))
					line_chars.push_back(($urandom_range(2) == 0) ? CH_SPACE : word_char(1'b1));
				if ($urandom_range(3) != 0) begin
					line_chars.push_back(CH_QUOTE);
					repeat ($urandom_range(2, 0))
						line_chars.push_back(word_char(1'b1));
				end
			end
		end
		if ($urandom_range(3) == 0)
			line_chars.push_back(CH_SPACE);
		if ($urandom_range(9) == 0 && line_chars.size() > 1) begin
			cut = $urandom_range(line_chars.size(), 1);
			while (line_chars.size() > cut)
				void'(line_chars.pop_back());
		end
	endtask

	task automatic send_line();
		foreach (line_chars[i])
			send_char(line_chars[i], i == line_chars.size() - 1);
	endtask

	initial begin
		int line_count;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text(" ab = =c", 1'b1);
		send_text("=\"a b\" k", 1'b1);
		send_char(16'hFFFF, 1'b0);
		send_char(16'h0000, 1'b0);
		send_char(CH_EQUAL, 1'b1);
		send_text("x ", 1'b1);
		send_text(" ", 1'b1);
		send_text("a=b ", 1'b1);
		drain();

		items_sent = 0;
		line_count = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (line_count == 6) begin
				hold_ticket <= hold_ticket + 1;
				no_idle <= 1'b1;
				repeat (8)
					send_text("k=v ", 1'b0);
				send_text("z", 1'b1);
				no_idle <= 1'b0;
				drain();
			end
			no_idle <= ($urandom_range(99) < 15);
			build_line();
			send_line();
			if ($urandom_range(9) == 0)
				drain();
			line_count++;
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/kvot_pkg.sv
sv/kvot_front.sv
sv/kvot_back.sv
sv/key_value_option_tokenizer_core.sv
tb/tb_key_value_option_tokenizer_core.sv
